@@ src/cbm_pkg.sv @@
`default_nettype none

package cbm_pkg;

    // Kinds of bus request on the input stream.
    typedef enum logic [1:0] {
        REQ_ROM_READ  = 2'd0,
        REQ_REG_WRITE = 2'd1,
        REQ_RAM_READ  = 2'd2,
        REQ_RAM_WRITE = 2'd3
    } t_req;

    // Target of the resulting memory access.
    typedef enum logic [1:0] {
        SEL_NONE = 2'd0,
        SEL_ROM  = 2'd1,
        SEL_RAM  = 2'd2,
        SEL_RSVD = 2'd3
    } t_sel;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [2:0] CFG_ROM_BYTES   = 3'd0;
    localparam logic [2:0] CFG_ROM_NBANKS  = 3'd1;
    localparam logic [2:0] CFG_RAM_BYTES   = 3'd2;
    localparam logic [2:0] CFG_RAM_NBANKS  = 3'd3;
    localparam logic [2:0] CFG_RAM_PRESENT = 3'd4;

    // Bus address map.
    localparam logic [15:0] ADDR_ROM_HI   = 16'h4000;
    localparam logic [15:0] ADDR_RAM_BASE = 16'hA000;
    localparam logic [23:0] UNMAPPED_SPAN = 24'h008000;
    localparam logic [3:0]  RAM_EN_KEY    = 4'hA;

    // Field widths of the streams.
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

endpackage

`default_nettype wire

@@ src/cartridge_bank_mapper.sv @@
`default_nettype none

// Bank mapper for a multi-game cartridge. Each request on the input stream is
// a ROM read, a register write in the ROM area, a RAM read or a RAM write; it
// produces one result carrying the memory select, the physical byte offset,
// the write strobe and data, and the sticky save-dirty flag. The block takes
// one request per clock and registers its result in an output register; the
// input stalls only while that register holds a result that the downstream
// side has not taken. Before the mapped bit is set, ROM reads see the last
// 32 KiB of the ROM; once it is set, the outer bank bits, masks and multiplex
// mode are frozen. Offsets beyond the configured sizes give select none. The user
// must set sizes and bank counts over the APB port only while no request is in
// flight; the block itself does not enforce this.
module cartridge_bank_mapper #(
    parameter int ROM_OFFSET_BITS = 23
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // Request stream.
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    // tdata: address[15:0], write_data[23:16]
    input  wire  [cbm_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // tuser: req_type[1:0]
    input  wire  [1:0]                   s_axis_tuser,
    // Result stream.
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    // tdata: phys_offset[22:0], mem_write[23], mem_write_data[31:24],
    //        save_dirty[32], zero[39:33]
    output logic [cbm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: mem_select[1:0]
    output logic [1:0]                   m_axis_tuser,
    // Configuration port.
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [4:0]                   paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import cbm_pkg::*;

    // Configuration registers.
    logic [23:0] r_rom_bytes;
    logic [9:0]  r_rom_nbanks;
    logic [17:0] r_ram_bytes;
    logic [4:0]  r_ram_nbanks;
    logic        r_ram_present;

    // Mapper state.
    logic       r_ram_enable,   n_ram_enable;
    logic       r_mapped,       n_mapped;
    logic [4:0] r_rom_low,      n_rom_low;
    logic [1:0] r_rom_mid,      n_rom_mid;
    logic [1:0] r_rom_high,     n_rom_high;
    logic [4:0] r_rom_lock,     n_rom_lock;
    logic [1:0] r_ram_low,      n_ram_low;
    logic [1:0] r_ram_high,     n_ram_high;
    logic [1:0] r_ram_lock,     n_ram_lock;
    logic       r_mode_lock,    n_mode_lock;
    logic       r_bank_mode,    n_bank_mode;
    logic       r_mux_mode,     n_mux_mode;
    logic       r_dirty,        n_dirty;

    // Result register.
    logic        r_out_valid;
    logic [1:0]  r_sel,   n_sel;
    logic [22:0] r_off,   n_off;
    logic        r_wr,    n_wr;
    logic [7:0]  r_wdata, n_wdata;
    logic        r_out_dirty;

    // Request fields.
    t_req        req;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        accept;

    // Intermediate mapping values.
    logic        low_window;
    logic [4:0]  rom_lo_bits;
    logic [1:0]  rom_mid_sel;
    logic [8:0]  rom_bank_raw;
    logic [8:0]  rom_bank;
    logic [9:0]  rom_bank_and;
    logic [15:0] rom_win_off;
    logic [23:0] rom_base;
    logic [24:0] rom_off;
    logic        rom_hit;
    logic [1:0]  ram_lo_bits;
    logic [3:0]  ram_bank;
    logic [4:0]  ram_bank_and;
    logic [31:0] ram_off;
    logic        ram_hit;
    logic        ram_open;

    assign req    = t_req'(s_axis_tuser);
    assign addr   = s_axis_tdata[15:0];
    assign wdata  = s_axis_tdata[23:16];
    assign accept = s_axis_tvalid && s_axis_tready;

    // Take a new request whenever the result register is free or draining.
    assign s_axis_tready = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_sel;
    assign m_axis_tdata  = {7'd0, r_out_dirty, r_wdata, r_wr, r_off};

    assign pready = 1'b1;

    // Register readback.
    always_comb begin
        unique case (paddr[4:2])
            CFG_ROM_BYTES:   prdata = {8'd0, r_rom_bytes};
            CFG_ROM_NBANKS:  prdata = {22'd0, r_rom_nbanks};
            CFG_RAM_BYTES:   prdata = {14'd0, r_ram_bytes};
            CFG_RAM_NBANKS:  prdata = {27'd0, r_ram_nbanks};
            CFG_RAM_PRESENT: prdata = {31'd0, r_ram_present};
            default:         prdata = 32'd0;
        endcase
    end

    // ROM bank selection for the two windows.
    always_comb begin
        low_window = addr < ADDR_ROM_HI;
        if (low_window) begin
            rom_lo_bits = r_rom_low & r_rom_lock;
            if (r_mux_mode) begin
                rom_mid_sel = r_bank_mode ? r_ram_low : (r_ram_low & r_ram_lock);
            end else begin
                rom_mid_sel = r_rom_mid;
            end
            rom_win_off = addr;
        end else begin
            // In the switchable window, if the unlocked low bank bits are zero, bit 0 is forced to one.
            rom_lo_bits = r_rom_low;
            if ((r_rom_low & ~r_rom_lock) == 5'd0) begin
                rom_lo_bits = r_rom_low | 5'd1;
            end
            rom_mid_sel = r_mux_mode ? r_ram_low : r_rom_mid;
            rom_win_off = addr - ADDR_ROM_HI;
        end
        rom_bank_raw = {r_rom_high, rom_mid_sel, rom_lo_bits};
        rom_bank_and = r_rom_nbanks - 10'd1;
        rom_bank     = (r_rom_nbanks != 10'd0) ? (rom_bank_raw & rom_bank_and[8:0])
                                               : rom_bank_raw;
    end

    // ROM offset and range check.
    always_comb begin
        rom_base = (r_rom_bytes >= UNMAPPED_SPAN) ? (r_rom_bytes - UNMAPPED_SPAN) : 24'd0;
        if (!r_mapped) begin
            rom_off = {1'b0, rom_base} + {9'd0, addr};
        end else begin
            rom_off = {2'd0, rom_bank, 14'd0} + {9'd0, rom_win_off};
        end
        rom_hit = (rom_off < {1'b0, r_rom_bytes}) && ((rom_off >> ROM_OFFSET_BITS) == 25'd0);
    end

    // RAM bank selection, offset and range check.
    always_comb begin
        if (r_mux_mode) begin
            ram_lo_bits = r_rom_mid;
        end else begin
            ram_lo_bits = r_bank_mode ? r_ram_low : (r_ram_low & r_ram_lock);
        end
        ram_bank_and = r_ram_nbanks - 5'd1;
        ram_bank     = (r_ram_nbanks != 5'd0) ? ({r_ram_high, ram_lo_bits} & ram_bank_and[3:0])
                                              : {r_ram_high, ram_lo_bits};
        ram_off  = {15'd0, ram_bank, 13'd0} + {16'd0, addr} - {16'd0, ADDR_RAM_BASE};
        ram_hit  = (ram_off[31:18] == 14'd0) && (ram_off[17:0] < r_ram_bytes);
        ram_open = r_ram_enable && r_ram_present;
    end

    // Next mapper state and result for the current request.
    always_comb begin
        n_ram_enable = r_ram_enable;
        n_mapped     = r_mapped;
        n_rom_low    = r_rom_low;
        n_rom_mid    = r_rom_mid;
        n_rom_high   = r_rom_high;
        n_rom_lock   = r_rom_lock;
        n_ram_low    = r_ram_low;
        n_ram_high   = r_ram_high;
        n_ram_lock   = r_ram_lock;
        n_mode_lock  = r_mode_lock;
        n_bank_mode  = r_bank_mode;
        n_mux_mode   = r_mux_mode;
        n_dirty      = r_dirty;
        n_sel        = SEL_NONE;
        n_off        = 23'd0;
        n_wr         = 1'b0;
        n_wdata      = 8'd0;

        unique case (req)
            REQ_ROM_READ: begin
                if (rom_hit) begin
                    n_sel = SEL_ROM;
                    n_off = rom_off[22:0];
                end
            end
            REQ_REG_WRITE: begin
                // Register writes decode on the top three address bits.
                unique case (addr[15:13])
                    3'd0: begin
                        n_ram_enable = wdata[3:0] == RAM_EN_KEY;
                        if (!r_mapped) begin
                            n_ram_lock = wdata[5:4];
                            n_mapped   = wdata[6];
                        end
                    end
                    3'd1: begin
                        n_rom_low = (r_rom_low & r_rom_lock) | (wdata[4:0] & ~r_rom_lock);
                        if (!r_mapped) begin
                            n_rom_mid = wdata[6:5];
                        end
                    end
                    3'd2: begin
                        n_ram_low = (r_ram_low & r_ram_lock) | (wdata[1:0] & ~r_ram_lock);
                        if (!r_mapped) begin
                            n_ram_high  = wdata[3:2];
                            n_rom_high  = wdata[5:4];
                            n_mode_lock = wdata[6];
                        end
                    end
                    3'd3: begin
                        if (!r_mode_lock) begin
                            n_bank_mode = wdata[0];
                        end
                        if (!r_mapped) begin
                            n_rom_lock = {wdata[5:2], 1'b0};
                            n_mux_mode = wdata[6];
                        end
                    end
                    default: begin
                    end
                endcase
            end
            REQ_RAM_READ, REQ_RAM_WRITE: begin
                if (ram_open) begin
                    if (req == REQ_RAM_WRITE) begin
                        n_dirty = 1'b1;
                    end
                    if (ram_hit) begin
                        n_sel = SEL_RAM;
                        n_off = ram_off[22:0];
                        if (req == REQ_RAM_WRITE) begin
                            n_wr    = 1'b1;
                            n_wdata = wdata;
                        end
                    end
                end
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_bytes   <= 24'd32768;
            r_rom_nbanks  <= 10'd2;
            r_ram_bytes   <= 18'd0;
            r_ram_nbanks  <= 5'd0;
            r_ram_present <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[4:2])
                CFG_ROM_BYTES:   r_rom_bytes   <= pwdata[23:0];
                CFG_ROM_NBANKS:  r_rom_nbanks  <= pwdata[9:0];
                CFG_RAM_BYTES:   r_ram_bytes   <= pwdata[17:0];
                CFG_RAM_NBANKS:  r_ram_nbanks  <= pwdata[4:0];
                CFG_RAM_PRESENT: r_ram_present <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Mapper state updates on each accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_enable <= 1'b0;
            r_mapped     <= 1'b0;
            r_rom_low    <= 5'd0;
            r_rom_mid    <= 2'd0;
            r_rom_high   <= 2'd0;
            r_rom_lock   <= 5'd0;
            r_ram_low    <= 2'd0;
            r_ram_high   <= 2'd0;
            r_ram_lock   <= 2'd0;
            r_mode_lock  <= 1'b0;
            r_bank_mode  <= 1'b0;
            r_mux_mode   <= 1'b0;
            r_dirty      <= 1'b0;
        end else if (accept) begin
            r_ram_enable <= n_ram_enable;
            r_mapped     <= n_mapped;
            r_rom_low    <= n_rom_low;
            r_rom_mid    <= n_rom_mid;
            r_rom_high   <= n_rom_high;
            r_rom_lock   <= n_rom_lock;
            r_ram_low    <= n_ram_low;
            r_ram_high   <= n_ram_high;
            r_ram_lock   <= n_ram_lock;
            r_mode_lock  <= n_mode_lock;
            r_bank_mode  <= n_bank_mode;
            r_mux_mode   <= n_mux_mode;
            r_dirty      <= n_dirty;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sel       <= n_sel;
            r_off       <= n_off;
            r_wr        <= n_wr;
            r_wdata     <= n_wdata;
            r_out_dirty <= n_dirty;
        end
    end

endmodule

`default_nettype wire

@@ src/cbm_checker.sv @@
`default_nettype none

module cbm_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            s_axis_tvalid,
    input wire                            s_axis_tready,
    input wire                            m_axis_tvalid,
    input wire                            m_axis_tready,
    input wire [cbm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input wire [1:0]                      m_axis_tuser
);
    import cbm_pkg::*;

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Every accepted request shows a result in the next cycle.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted request produced no result");

    // The input is never blocked while the result register is empty.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // A result with no target carries a zero offset and no write.
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == SEL_NONE |->
            m_axis_tdata[22:0] == 23'd0 && !m_axis_tdata[23])
        else $error("unselected result has offset or write");

    // A write strobe only goes to RAM and always marks the save dirty.
    a_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[23] |->
            m_axis_tuser == SEL_RAM && m_axis_tdata[32])
        else $error("write strobe without RAM select or dirty flag");

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
